// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the frame builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMFB_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define SMFB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smfb_pkg.sv =====
// Package with the types, constants and check-octet function of the frame builder.
package smfb_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 15;
    localparam int unsigned RES_MAX = 6;
    localparam int unsigned CNT_W   = 3;

    localparam logic [7:0] FCS_POLY       = 8'hE0;
    localparam logic [7:0] FCS_INIT       = 8'hFF;
    localparam logic [7:0] UIH_MASK       = 8'hEF;
    localparam logic [7:0] UIH_CODE       = 8'hEF;
    localparam logic [7:0] CREDIT_CONTROL = 8'hFF;
    localparam logic [LEN_W-1:0] SHORT_LEN_LIMIT = 15'd128;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    typedef struct packed {
        logic [RES_MAX-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               count;
        logic                           last;
    } t_result;

    typedef struct packed {
        logic [LEN_W-1:0]  bytes_left;
        logic [BYTE_W-1:0] held_check;
        logic              frame_open;
    } t_frame_state;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] control;
        logic [BYTE_W-1:0] credits;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] crc_ac;
    } t_item;

    // Reflected CRC-8 update over one octet, polynomial x^8+x^2+x+1.
    function automatic logic [7:0] fcs_feed(input logic [7:0] crc, input logic [7:0] octet);
        logic [7:0] c;
        c = crc ^ octet;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/smfb_frame_calc.sv =====
// Combinational octet list and next frame state for one registered item.
module smfb_frame_calc (
    input  smfb_pkg::t_item        i_item,
    input  smfb_pkg::t_frame_state i_state,
    output smfb_pkg::t_result      o_result,
    output smfb_pkg::t_frame_state o_state
);

    logic                           is_short;
    logic                           has_credit;
    logic                           is_uih;
    logic                           len_zero;
    logic [smfb_pkg::BYTE_W-1:0]    len_lo;
    logic [smfb_pkg::BYTE_W-1:0]    len_hi;
    logic [smfb_pkg::BYTE_W-1:0]    crc_all;
    logic [smfb_pkg::BYTE_W-1:0]    check;
    logic [smfb_pkg::LEN_W-1:0]     left_dec;

    always_comb begin
        is_short   = (i_item.length < smfb_pkg::SHORT_LEN_LIMIT);
        has_credit = (i_item.control == smfb_pkg::CREDIT_CONTROL);
        is_uih     = ((i_item.control & smfb_pkg::UIH_MASK) == smfb_pkg::UIH_CODE);
        len_zero   = (i_item.length == '0);
        len_lo     = is_short ? {i_item.length[6:0], 1'b1} : {i_item.length[6:0], 1'b0};
        len_hi     = i_item.length[14:7];
        crc_all    = smfb_pkg::fcs_feed(i_item.crc_ac, len_lo);
        if (!is_short) begin
            crc_all = smfb_pkg::fcs_feed(crc_all, len_hi);
        end
        check    = is_uih ? ~i_item.crc_ac : ~crc_all;
        left_dec = i_state.bytes_left - 15'd1;

        o_result = '0;
        o_state  = i_state;

        if (i_item.op == smfb_pkg::OP_HEADER) begin
            o_result.bytes[0] = i_item.address;
            o_result.bytes[1] = i_item.control;
            o_result.bytes[2] = len_lo;
            if (is_short) begin
                o_result.bytes[3] = has_credit ? i_item.credits : check;
                o_result.bytes[4] = check;
            end else begin
                o_result.bytes[3] = len_hi;
                o_result.bytes[4] = has_credit ? i_item.credits : check;
            end
            o_result.bytes[5] = check;
            o_result.count = 3'd2 + (is_short ? 3'd1 : 3'd2)
                           + {2'b00, has_credit} + {2'b00, len_zero};
            o_result.last  = len_zero;
            o_state.bytes_left = i_item.length;
            o_state.held_check = check;
            o_state.frame_open = !len_zero;
        end else if (i_state.frame_open) begin
            o_result.bytes[0]  = i_item.data_byte;
            o_result.bytes[1]  = i_state.held_check;
            o_state.bytes_left = left_dec;
            if (left_dec == '0) begin
                o_result.count     = 3'd2;
                o_result.last      = 1'b1;
                o_state.frame_open = 1'b0;
            end else begin
                o_result.count = 3'd1;
            end
        end
    end

endmodule

// ===== rtl/smfb_out_shifter.sv =====
// Output register that holds one item's octets and shifts them out one per transfer.
module smfb_out_shifter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  smfb_pkg::t_result           i_result,
    output logic                        o_load_ok,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [smfb_pkg::BYTE_W-1:0] o_m_axis_tdata,
    output logic                        o_m_axis_tlast
);

    logic [smfb_pkg::RES_MAX-1:0][smfb_pkg::BYTE_W-1:0] r_buf;
    logic [smfb_pkg::CNT_W-1:0]                          r_cnt;
    logic                                                r_last;
    logic                                                xfer;

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = r_buf[0];
    assign o_m_axis_tlast  = r_last && (r_cnt == 3'd1);
    assign xfer            = o_m_axis_tvalid && i_m_axis_tready;
    assign o_load_ok       = (r_cnt == '0) || ((r_cnt == 3'd1) && i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_result.count;
        end else if (xfer) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf  <= i_result.bytes;
            r_last <= i_result.last;
        end else if (xfer) begin
            for (int i = 0; i < smfb_pkg::RES_MAX - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

endmodule

// ===== rtl/serial_mux_frame_builder_core.sv =====
// Top level of the multiplexer basic-frame builder with frame check octet.
//
// The block turns header and payload items into a stream of frame octets. An
// input transfer lands in an input register; short combinational logic then
// forms the item's octets and the next frame state in one pass and loads them
// into an output shift register, which sends one octet per output transfer.
// While the output is not stalled, payload streams at one octet per clock;
// the final payload item also carries the check octet. A header item emits
// address, control, one or two length octets, an optional credits octet,
// and the check octet when the length is zero, one octet per output
// transfer through the single-octet output port. A payload item with no open
// frame is dropped without emitting anything. An input transfer passes
// through the input register and the output register before its first
// octet appears. tlast marks the check octet that closes a frame; a frame
// abandoned by a new header ends without one.
module serial_mux_frame_builder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata, lowest bit up: address[7:0], control[15:8], credits[23:16],
    // length[38:24], data_byte[46:39], zero pad[47].
    input  logic [47:0] i_s_axis_tdata,
    // tuser: op[0] (0 = header item, 1 = payload item).
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: out_byte[7:0].
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    // Input register: holds one item until its octets can move to the output.
    logic                   r_in_valid;
    smfb_pkg::t_item        r_item;
    smfb_pkg::t_item        n_item;

    // Frame state carried from item to item.
    smfb_pkg::t_frame_state r_state;
    smfb_pkg::t_frame_state n_state;

    smfb_pkg::t_result      calc_result;
    logic                   load_ok;
    logic                   advance;
    logic                   in_xfer;

    // The item leaves the input register when it emits nothing or when the
    // output register is empty or emptying in this cycle.
    assign advance = r_in_valid && ((calc_result.count == '0) || load_ok);
    assign o_s_axis_tready = i_rst_n && (!r_in_valid || advance);
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // The address/control part of the check octet only depends on the input
    // fields, so it is formed on the way into the input register.
    always_comb begin
        n_item.op        = i_s_axis_tuser;
        n_item.address   = i_s_axis_tdata[7:0];
        n_item.control   = i_s_axis_tdata[15:8];
        n_item.credits   = i_s_axis_tdata[23:16];
        n_item.length    = i_s_axis_tdata[38:24];
        n_item.data_byte = i_s_axis_tdata[46:39];
        n_item.crc_ac    = smfb_pkg::fcs_feed(
                               smfb_pkg::fcs_feed(smfb_pkg::FCS_INIT, i_s_axis_tdata[7:0]),
                               i_s_axis_tdata[15:8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    smfb_frame_calc u_calc (
        .i_item   (r_item),
        .i_state  (r_state),
        .o_result (calc_result),
        .o_state  (n_state)
    );

    smfb_out_shifter u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (advance && (calc_result.count != '0)),
        .i_result        (calc_result),
        .o_load_ok       (load_ok),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// ===== rtl/smfb_checker.sv =====
// Port-level checker for the frame builder and its bind to the top level.
`include "assert_macros.svh"

module smfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  i_m_tdata,
    input logic        i_m_tlast
);

    // A stalled output octet keeps its value and its end-of-frame mark.
    `SMFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast), "smfb: stalled output changed")

    // Reset empties the output register.
    `SMFB_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_m_tvalid, "smfb: output valid after reset")

    // With nothing waiting on the output side, the input side is never held off.
    `SMFB_ASSERT(a_idle_ready, i_clk, i_rst_n, !i_m_tvalid, i_s_tready, "smfb: input stalled while output idle")

    // Output starts only after an input transfer has passed the input and output registers.
    `SMFB_ASSERT(a_rise_src, i_clk, i_rst_n, $rose(i_m_tvalid), $past(i_s_tvalid && i_s_tready, 2), "smfb: output without an input transfer")

endmodule

bind serial_mux_frame_builder_core smfb_checker u_smfb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);

// ===== dv/serial_mux_frame_builder_core_tb.sv =====
// Self-checking testbench for the multiplexer basic-frame builder core.
module serial_mux_frame_builder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Input items offered over the whole run, dropped ones included.
    localparam int ITEM_TARGET = 230;

    // One octet expected on the output stream; closes marks the check octet.
    typedef struct packed {
        logic [7:0] octet;
        logic       closes;
    } t_octet;

    // Tracks the open frame and predicts the octets that each accepted input
    // transfer produces, then checks the output transfers against them in order.
    class t_frame_model;
        t_octet      octet_queue[$];
        logic [14:0] payload_left;
        logic [7:0]  frame_check;
        bit          open_frame;
        int          error_count;
        int          octets_checked;
        int          frames_closed;
        int          frames_abandoned;
        int          items_dropped;

        function new();
            payload_left     = '0;
            frame_check      = '0;
            open_frame       = 1'b0;
            error_count      = 0;
            octets_checked   = 0;
            frames_closed    = 0;
            frames_abandoned = 0;
            items_dropped    = 0;
        endfunction

        // Reflected CRC-8, one input bit at a time, least significant bit first.
        function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] octet);
            logic fb;
            for (int b = 0; b < 8; b++) begin
                fb  = crc[0] ^ octet[b];
                crc = crc >> 1;
                if (fb) crc = crc ^ smfb_pkg::FCS_POLY;
            end
            return crc;
        endfunction

        function void queue_octet(logic [7:0] octet, logic closes);
            octet_queue.push_back('{octet: octet, closes: closes});
        endfunction

        function int pending();
            return octet_queue.size();
        endfunction

        // Returns the number of octets the transfer will produce.
        function int note_item(logic op, logic [7:0] addr, logic [7:0] ctrl,
                               logic [7:0] cred, logic [14:0] len, logic [7:0] data);
            logic [7:0] crc_head;
            logic [7:0] crc_len;
            logic [7:0] len_lo;
            int         before_cnt;
            before_cnt = octet_queue.size();
            if (op == smfb_pkg::OP_HEADER) begin
                // A header while a frame is open drops that frame's check octet.
                if (open_frame) frames_abandoned++;
                crc_head = crc8_step(crc8_step(smfb_pkg::FCS_INIT, addr), ctrl);
                queue_octet(addr, 1'b0);
                queue_octet(ctrl, 1'b0);
                if (len < smfb_pkg::SHORT_LEN_LIMIT) begin
                    len_lo  = {len[6:0], 1'b1};
                    queue_octet(len_lo, 1'b0);
                    crc_len = crc8_step(crc_head, len_lo);
                end else begin
                    len_lo  = {len[6:0], 1'b0};
                    queue_octet(len_lo, 1'b0);
                    queue_octet(len[14:7], 1'b0);
                    crc_len = crc8_step(crc8_step(crc_head, len_lo), len[14:7]);
                end
                if (ctrl == smfb_pkg::CREDIT_CONTROL) queue_octet(cred, 1'b0);
                // UIH frames protect only address and control.
                frame_check = ((ctrl & smfb_pkg::UIH_MASK) == smfb_pkg::UIH_CODE) ?
                              ~crc_head : ~crc_len;
                if (len == '0) begin
                    queue_octet(frame_check, 1'b1);
                    open_frame   = 1'b0;
                    payload_left = '0;
                    frames_closed++;
                end else begin
                    open_frame   = 1'b1;
                    payload_left = len;
                end
            end else if (open_frame) begin
                queue_octet(data, 1'b0);
                payload_left = payload_left - 1'b1;
                if (payload_left == '0) begin
                    queue_octet(frame_check, 1'b1);
                    open_frame = 1'b0;
                    frames_closed++;
                end
            end else begin
                items_dropped++;
            end
            return octet_queue.size() - before_cnt;
        endfunction

        function void check_octet(logic [7:0] got, logic got_last);
            t_octet want;
            if (octet_queue.size() == 0) begin
                error_count++;
                $error("out_byte 0x%02h (last %0b) arrived with nothing expected",
                       got, got_last);
                return;
            end
            want = octet_queue.pop_front();
            octets_checked++;
            if (got !== want.octet) begin
                error_count++;
                $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", want.octet, got);
            end
            if (got_last !== want.closes) begin
                error_count++;
                $error("last mismatch: expected %0b, actual %0b", want.closes, got_last);
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // tdata, lowest bit up: address[7:0], control[15:8], credits[23:16],
    // length[38:24], data_byte[46:39], zero pad[47].
    logic [47:0] i_s_axis_tdata  = '0;
    // tuser: op[0].
    logic        i_s_axis_tuser  = smfb_pkg::OP_HEADER;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // tdata: out_byte[7:0].
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;

    t_frame_model fm = new();

    bit calm          = 1'b0;  // both sides stop idling while set
    bit stall_request = 1'b0;  // asks the receiver for one long hold-off
    int items_used    = 0;     // transfers the block acts on (dropped ones excluded)
    int items_sent    = 0;     // every input transfer, dropped ones included

    always #1 i_clk = ~i_clk;

    serial_mux_frame_builder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Offers one item, with a random gap in front, and waits for its transfer.
    // tvalid stays high afterwards so back-to-back items need no extra step.
    task automatic send_item(logic op, logic [7:0] addr, logic [7:0] ctrl,
                             logic [7:0] cred, logic [14:0] len, logic [7:0] data);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 21) gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {1'b0, data, len, cred, ctrl, addr};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (fm.note_item(op, addr, ctrl, cred, len, data) > 0) items_used++;
    endtask

    // Fields that the item kind does not use are filled with noise.
    task automatic send_header(logic [7:0] addr, logic [7:0] ctrl, logic [7:0] cred,
                               logic [14:0] len);
        send_item(smfb_pkg::OP_HEADER, addr, ctrl, cred, len, 8'($urandom_range(255)));
    endtask

    task automatic send_payload(logic [7:0] data);
        send_item(smfb_pkg::OP_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 15'($urandom_range(32767)), data);
    endtask

    // Sender goes quiet until every predicted octet has been seen.
    task automatic drain_output();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (fm.pending() != 0) @(posedge i_clk);
    endtask

    // Receiver: checks each output transfer, then picks tready for the next
    // cycle. The long hold-off is counted here so the sender keeps pushing.
    initial begin : receiver
        int hold_left;
        bit stall_done;
        hold_left  = 0;
        stall_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                fm.check_octet(o_m_axis_tdata, o_m_axis_tlast);
            if (stall_request && !stall_done) begin
                hold_left  = 300;
                stall_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    initial begin : stimulus
        int          random_base;
        int          pick;
        int          payload_cnt;
        int          budget;
        bit          drained_mid;
        logic [7:0]  ctrl;
        logic [14:0] len;
        drained_mid = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: dropped payload, zero-length frames with and without
        // credits, both length forms, UIH and non-UIH, abandoned frames, and
        // the field extremes.
        send_payload(8'h5A);
        send_header(8'h00, smfb_pkg::CREDIT_CONTROL, 8'hA5, 15'd0);
        send_header(8'hFF, smfb_pkg::UIH_CODE, 8'h00, 15'd1);
        send_payload(8'hFF);
        send_header(8'h1B, 8'h3F, 8'hFF, 15'd127);
        send_header(8'h03, smfb_pkg::CREDIT_CONTROL, 8'h00, 15'd128);
        send_payload(8'h00);
        send_payload(8'h81);
        send_header(8'h55, 8'h00, 8'h7E, 15'd32767);
        send_payload(8'h3C);
        send_header(8'hAA, 8'h03, 8'h11, 15'd2);
        send_payload(8'h00);
        send_payload(8'h80);
        send_payload(8'h77);
        send_header(8'h07, 8'h53, 8'hC3, 15'd0);
        send_header(8'hFE, smfb_pkg::UIH_CODE, 8'h42, 15'd3);
        send_payload(8'h01);
        send_payload(8'hFE);
        send_payload(8'h7F);
        drain_output();

        // One complete frame with a two-octet length field, sent while the
        // receiver holds off so that the block fills up and stalls its input.
        random_base   = items_sent;
        stall_request = 1'b1;
        len = 15'($urandom_range(140, 128));
        send_header(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), len);
        repeat (len) send_payload(8'($urandom_range(255)));

        // Random part: mostly complete frames, some truncated ones, some noise.
        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent - random_base >= 145) && (items_sent - random_base < 185);
            if (!drained_mid && items_sent - random_base >= 190) begin
                drain_output();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_payload(8'($urandom_range(255)));
            end else begin
                case ($urandom_range(99)) inside
                    [0:14]:  ctrl = smfb_pkg::CREDIT_CONTROL;
                    [15:29]: ctrl = smfb_pkg::UIH_CODE;
                    default: ctrl = 8'($urandom_range(255));
                endcase
                case ($urandom_range(99)) inside
                    [0:14]:  len = 15'd0;
                    [15:74]: len = 15'($urandom_range(8, 1));
                    [75:92]: len = 15'($urandom_range(127, 9));
                    default: len = 15'($urandom_range(32767, 128));
                endcase
                if (len == '0)
                    payload_cnt = 0;
                else if (len >= smfb_pkg::SHORT_LEN_LIMIT)
                    payload_cnt = $urandom_range(6, 0);
                else if (pick < 15)
                    payload_cnt = $urandom_range(int'(len) - 1, 0);
                else
                    payload_cnt = int'(len);
                // Keep the run near its item count; a cut frame stays open.
                budget = ITEM_TARGET - items_sent - 1;
                if (payload_cnt > budget) payload_cnt = budget;
                send_header(8'($urandom_range(255)), ctrl, 8'($urandom_range(255)), len);
                repeat (payload_cnt) send_payload(8'($urandom_range(255)));
            end
        end
        calm = 1'b0;

        drain_output();
        repeat (20) @(posedge i_clk);
        $display("Accepted %0d active input transfers plus %0d dropped payload items;",
                 items_used, fm.items_dropped);
        $display("%0d octets checked, %0d frames closed, %0d abandoned, %0d mismatches.",
                 fm.octets_checked, fm.frames_closed, fm.frames_abandoned,
                 fm.error_count);
        if (fm.error_count == 0 && fm.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #400us;
        $display("FAIL");
        $finish;
    end

endmodule
